// ----- design/msp_pkg.sv -----
// ---------------------------------------------------------------------------
// msp_pkg: shared types and constants for the merkle sum parent node
// Beat types, SHA-256 round constants, initial hash words, block helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	// truncated hash width in bytes (1 to 8)
	localparam int HASH_BYTES = 8;
	localparam int SUM_BYTES  = 8;
	localparam int MSG_BYTES  = SUM_BYTES + 2 * HASH_BYTES;
	localparam logic [63:0] MSG_BITS = 64'(MSG_BYTES * 8);
	localparam int ROUNDS     = 64;

	// input beat
	typedef struct packed {
		logic signed [63:0] left_sum;
		logic        [63:0] left_hash;
		logic signed [63:0] right_sum;
		logic        [63:0] right_hash;
	} item_t;

	// result beat
	typedef struct packed {
		logic signed [63:0] parent_sum;
		logic        [63:0] parent_hash;
		logic               sum_overflow;
	} result_t;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// padded single block, byte 0 in the top bits
	function automatic logic [511:0] build_block(input logic [63:0] ps,
			input logic [63:0] lh, input logic [63:0] rh);
		logic [511:0] blk;
		logic [7:0]   b;
		int           j;
		blk = '0;
		for (int i = 0; i < 64; i++) begin
			b = 8'h00;
			if (i < SUM_BYTES) begin
				b = ps[8*i +: 8];
			end else if (i < SUM_BYTES + HASH_BYTES) begin
				j = i - SUM_BYTES;
				b = lh[8*(HASH_BYTES-1-j) +: 8];
			end else if (i < MSG_BYTES) begin
				j = i - SUM_BYTES - HASH_BYTES;
				b = rh[8*(HASH_BYTES-1-j) +: 8];
			end else if (i == MSG_BYTES) begin
				b = 8'h80;
			end else if (i >= 56) begin
				b = MSG_BITS[8*(63-i) +: 8];
			end
			blk[511-8*i -: 8] = b;
		end
		return blk;
	endfunction

endpackage

`default_nettype wire

// ----- design/merkle_sum_parent_node_core.sv -----
// An input beat is loaded, then the single SHA-256 round unit does one of 64
// rounds per cycle, and the finish state writes the result into the output
// register once it is free. A new item is taken only when back in idle.
// A waiting result sits in the output register while the next item runs.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops
// the result valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
// merkle_sum_parent_node_core: merkle sum tree parent node
// Adds the child sums and hashes sum and child hashes with one SHA-256 block.
// ---------------------------------------------------------------------------
`default_nettype none

module merkle_sum_parent_node_core
	import msp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ROUND  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t             state_q;
	logic [5:0]         rnd_q;
	logic [31:0]        w_q [16];
	logic [31:0]        a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic signed [63:0] sum_q;
	logic               ovf_q;
	logic               result_valid_q;
	result_t            result_q;

	logic               in_acc;
	logic               out_free;
	logic signed [63:0] sum_d;
	logic               ovf_d;
	logic [511:0]       blk_d;
	logic [31:0]        w_next, t1, t2;
	logic [63:0]        dig_top;

	assign in_acc   = item_valid && (state_q == ST_IDLE);
	assign out_free = !result_valid_q || !result_stall;

	// child sum, overflow and padded block
	always_comb begin
		sum_d = item.left_sum + item.right_sum;
		ovf_d = ~(item.left_sum[63] ^ item.right_sum[63]) &
			(item.left_sum[63] ^ sum_d[63]);
		blk_d = build_block(sum_d, item.left_hash, item.right_hash);
	end

	// shared round unit and schedule word
	always_comb begin
		w_next = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);
		t1 = h_q + big_sig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) +
			ROUND_K[rnd_q] + w_q[0];
		t2 = big_sig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
		dig_top = {INIT_H[0] + a_q, INIT_H[1] + b_q};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_d[511-32*i -: 32];
			end
			a_q   <= INIT_H[0];
			b_q   <= INIT_H[1];
			c_q   <= INIT_H[2];
			d_q   <= INIT_H[3];
			e_q   <= INIT_H[4];
			f_q   <= INIT_H[5];
			g_q   <= INIT_H[6];
			h_q   <= INIT_H[7];
			sum_q <= sum_d;
			ovf_q <= ovf_d;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result_q.parent_sum   <= sum_q;
			result_q.parent_hash  <= dig_top >> (64 - 8 * HASH_BYTES);
			result_q.sum_overflow <= ovf_q;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- design/msp_checker.sv -----
// ---------------------------------------------------------------------------
// msp_checker: port-level checks for the merkle sum parent node
// Watches the handshakes over time and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module msp_checker
	import msp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// a stalled input beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input beat changed");

	// an accepted beat closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after accept");

	// input is still closed in the last round
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> ##64 item_stall)
		else $error("input reopened before rounds finished");

	// a fresh result appears only as the input side reopens
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("result raised while still busy");

endmodule

bind merkle_sum_parent_node_core msp_checker u_msp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// ----- verif/merkle_sum_parent_node_core_test.sv -----
// ---------------------------------------------------------------------------
// merkle_sum_parent_node_core_test: testbench for the merkle sum parent node
// Drives child node pairs, predicts each parent (wrapped sum, overflow flag,
// truncated SHA-256 over sum and child hashes) and checks every result beat
// in order, with random idling and stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module merkle_sum_parent_node_core_test
	import msp_pkg::*;
();

	localparam int NODE_HASH_BYTES = msp_pkg::HASH_BYTES;
	localparam int RAND_BLOCKS     = 13;
	localparam int BLOCK_ITEMS     = 150;
	localparam int NODE_LATENCY    = 70;
	localparam int QUIET_LIMIT     = 1000;
	localparam int NUM_DIRECTED    = 16;

	localparam logic [63:0] SUM_MAX = 64'h7fffffffffffffff;
	localparam logic [63:0] SUM_MIN = 64'h8000000000000000;
	localparam logic [63:0] ONES    = 64'hffffffffffffffff;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// one directed row; sum and flag are typed in only where pinned is set
	typedef struct packed {
		logic [63:0] ls;
		logic [63:0] lh;
		logic [63:0] rs;
		logic [63:0] rh;
		logic        pinned;
		logic [63:0] sum;
		logic        ovf;
	} node_row_t;

	node_row_t directed_nodes [NUM_DIRECTED] = '{
		'{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h0, 1'b0},
		'{SUM_MAX, 64'h0, 64'h1, 64'h0, 1'b1, SUM_MIN, 1'b1},
		'{SUM_MIN, 64'h0, ONES, 64'h0, 1'b1, SUM_MAX, 1'b1},
		'{SUM_MIN, ONES, SUM_MIN, ONES, 1'b1, 64'h0, 1'b1},
		'{SUM_MAX, ONES, SUM_MAX, ONES, 1'b1, 64'hfffffffffffffffe, 1'b1},
		'{SUM_MAX, 64'h0, SUM_MIN, ONES, 1'b1, ONES, 1'b0},
		'{ONES, 64'h0123456789abcdef, 64'h1, 64'hfedcba9876543210, 1'b1, 64'h0, 1'b0},
		'{SUM_MIN, 64'h8000000000000000, 64'h0, 64'h1, 1'b1, SUM_MIN, 1'b0},
		'{SUM_MAX, 64'h0, 64'h0, 64'h7fffffffffffffff, 1'b1, SUM_MAX, 1'b0},
		'{ONES, ONES, ONES, ONES, 1'b1, 64'hfffffffffffffffe, 1'b0},
		'{SUM_MIN, 64'h0, 64'h1, 64'h0, 1'b1, 64'h8000000000000001, 1'b0},
		'{64'h4000000000000000, 64'h0, 64'h4000000000000000, ONES, 1'b1, SUM_MIN, 1'b1},
		'{64'hc000000000000000, ONES, 64'hbfffffffffffffff, 64'h0, 1'b1, SUM_MAX, 1'b1},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa,
			64'h5555555555555555, 1'b0, 64'h0, 1'b0},
		'{64'h0000000100000000, 64'h0, 64'h00000000ffffffff, 64'hdeadbeefcafef00d,
			1'b0, 64'h0, 1'b0},
		'{64'h0f0f0f0f0f0f0f0f, 64'h00ff00ff00ff00ff, 64'hf0f0f0f0f0f0f0f0,
			64'hff00ff00ff00ff00, 1'b0, 64'h0, 1'b0}
	};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	result_t expected_parents [$];
	int      mismatch_count = 0;
	int      quiet_cycles   = 0;
	bit      calm           = 1'b1;

	merkle_sum_parent_node_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		logic [63:0] twice;
		twice = {x, x} >> n;
		return twice[31:0];
	endfunction

	// parent node: wrapped sum, signed overflow, truncated digest
	function automatic result_t parent_of(input item_t node);
		result_t     r;
		logic [7:0]  blk [64];
		logic [31:0] w [64];
		logic [31:0] st [8];
		logic [31:0] t1, t2, s0, s1;
		logic [63:0] msg_bits;
		int          msg_len;
		r.parent_sum   = node.left_sum + node.right_sum;
		r.sum_overflow = (node.left_sum[63] == node.right_sum[63]) &&
			(r.parent_sum[63] != node.left_sum[63]);
		r.parent_hash  = '0;
		msg_len  = 8 + 2 * NODE_HASH_BYTES;
		msg_bits = 64'(msg_len * 8);

		// padded block: sum little-endian, then child hashes top byte first
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk[i] = r.parent_sum[8*i +: 8];
		for (int i = 0; i < NODE_HASH_BYTES; i++) begin
			blk[8 + i] = node.left_hash[8*(NODE_HASH_BYTES-1-i) +: 8];
			blk[8 + NODE_HASH_BYTES + i] = node.right_hash[8*(NODE_HASH_BYTES-1-i) +: 8];
		end
		blk[msg_len] = 8'h80;
		for (int i = 0; i < 8; i++) blk[63 - i] = msg_bits[8*i +: 8];

		// message schedule
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			end else begin
				s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
		end

		// compression rounds, working words a..h held in st[0..7]
		st = SHA_IV;
		for (int i = 0; i < 64; i++) begin
			t1 = st[7] + (ror32(st[4], 6) ^ ror32(st[4], 11) ^ ror32(st[4], 25)) +
				((st[4] & st[5]) ^ (~st[4] & st[6])) + SHA_K[i] + w[i];
			t2 = (ror32(st[0], 2) ^ ror32(st[0], 13) ^ ror32(st[0], 22)) +
				((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
			for (int j = 7; j > 0; j--) st[j] = st[j-1];
			st[4] = st[4] + t1;
			st[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) st[i] = st[i] + SHA_IV[i];

		// leading digest bytes, first byte ends up most significant
		for (int i = 0; i < NODE_HASH_BYTES; i++) begin
			r.parent_hash = {r.parent_hash[55:0], st[i/4][31 - 8*(i%4) -: 8]};
		end
		return r;
	endfunction

	// child sum biased towards the edges of the signed range
	function automatic logic [63:0] draw_sum();
		logic [31:0] lo;
		lo = $urandom;
		case ($urandom_range(0, 4))
			0: return {{32{lo[31]}}, lo};
			1: return SUM_MAX - 64'($urandom_range(0, 1000));
			2: return SUM_MIN + 64'($urandom_range(0, 1000));
			default: return {$urandom, lo};
		endcase
	endfunction

	task automatic flag(input string what);
		mismatch_count++;
		$display("mismatch: %s", what);
	endtask

	// present one child pair and hold it until the block takes it
	task automatic send_node(input item_t node, input result_t parent);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_parents = {expected_parents, parent};
		item       <= node;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	// hold the sender off until every parent has come back
	task automatic wait_for_parents();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_parents.size() != 0);
	endtask

	// stimulus
	initial begin
		item_t   node;
		result_t parent;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, back to back
		foreach (directed_nodes[i]) begin
			node.left_sum   = directed_nodes[i].ls;
			node.left_hash  = directed_nodes[i].lh;
			node.right_sum  = directed_nodes[i].rs;
			node.right_hash = directed_nodes[i].rh;
			parent = parent_of(node);
			if (directed_nodes[i].pinned) begin
				parent.parent_sum   = directed_nodes[i].sum;
				parent.sum_overflow = directed_nodes[i].ovf;
			end
			send_node(node, parent);
		end
		wait_for_parents();

		// random pairs in blocks, some blocks with no idling at all
		for (int blk_idx = 0; blk_idx < RAND_BLOCKS; blk_idx++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (blk_idx == RAND_BLOCKS / 2) wait_for_parents();
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				node.left_sum   = draw_sum();
				node.left_hash  = {$urandom, $urandom};
				node.right_sum  = draw_sum();
				node.right_hash = {$urandom, $urandom};
				send_node(node, parent_of(node));
			end
		end

		wait_for_parents();
		repeat (NODE_LATENCY) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// result side: stall for a drawn number of cycles once a beat is offered
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				result_stall <= 1'b1;
				do @(posedge clk); while (!result_valid);
				repeat (hold - 1) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// compare each accepted result beat with the oldest expected parent
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_parents.size() == 0) begin
				flag($sformatf("result beat with no parent expected, sum %h", result.parent_sum));
			end else begin
				want = expected_parents.pop_front();
				if (result.parent_sum !== want.parent_sum)
					flag($sformatf("parent_sum %h, want %h", result.parent_sum, want.parent_sum));
				if (result.parent_hash !== want.parent_hash)
					flag($sformatf("parent_hash %h, want %h", result.parent_hash,
						want.parent_hash));
				if (result.sum_overflow !== want.sum_overflow)
					flag($sformatf("sum_overflow %b, want %b", result.sum_overflow,
						want.sum_overflow));
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d parents outstanding",
				QUIET_LIMIT, expected_parents.size());
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire

// ----- files.f -----
design/msp_pkg.sv
design/merkle_sum_parent_node_core.sv
design/msp_checker.sv
verif/merkle_sum_parent_node_core_test.sv
